### hw/rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque with search.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package bdq_pkg;

	// Sizing of the cell row.
	localparam int DEPTH   = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// Fixed widths of the beat fields.
	localparam int DATA_W  = 32;
	localparam int ACT_W   = 3;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	// Action codes carried on the input beat.
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_SEARCH     = 3'd4
	} action_t;

	// Status codes carried on the result beat.
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// What a cell does at the next clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_LOAD = 2'd1,
		CELL_SHR  = 2'd2,
		CELL_SHL  = 2'd3
	} cell_op_t;

	// Outcome of the first-match search over the row.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} srch_t;

endpackage

### hw/rtl/bdq_cell.sv
// One storage cell of the deque row: holds one entry and compares it with the key.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_cell (
	input  logic                    clk,
	input  bdq_pkg::cell_op_t       op,
	input  logic [bdq_pkg::DATA_W-1:0] prev_data,
	input  logic [bdq_pkg::DATA_W-1:0] next_data,
	input  logic [bdq_pkg::DATA_W-1:0] load_data,
	input  logic [bdq_pkg::DATA_W-1:0] key,
	output logic [bdq_pkg::DATA_W-1:0] data,
	output logic                    hit
);
	import bdq_pkg::*;

	logic [DATA_W-1:0] data_q;

	// Entry register: load, take from the front neighbor or from the back neighbor.
	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD: data_q <= load_data;
			CELL_SHR:  data_q <= prev_data;
			CELL_SHL:  data_q <= next_data;
			CELL_HOLD: data_q <= data_q;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

	// Local compare for the search.
	assign hit = (data_q == key);

endmodule

### hw/rtl/bdq_search.sv
// Priority encoder that finds the frontmost matching cell of the row.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_search (
	input  logic [bdq_pkg::DEPTH-1:0] hits,
	output bdq_pkg::srch_t            result
);
	import bdq_pkg::*;

	// Walk from the back so the lowest matching index wins.
	always_comb begin
		result.found = 1'b0;
		result.idx   = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hits[i]) begin
				result.found = 1'b1;
				result.idx   = IDX_W'(i);
			end
		end
	end

endmodule

### hw/rtl/bounded_deque_with_search.sv
// Top level of the bounded deque with search: cell row, control and result register.
// Depends on bdq_pkg, bdq_cell and bdq_search.
`timescale 1ns / 1ps

// The block holds up to DEPTH (16) signed 32-bit entries in order from front to
// back and takes one action per input beat: push front, push back, pop front,
// pop back or search. Each action is done without sequencing, because the
// entries sit in a row of cells that all shift by one place together on a push
// or pop at the front and all compare against the key together on a search. A
// new beat can be accepted every cycle while in_stall is low; its result beat
// appears in the next cycle from the output register and stays there while
// out_stall is high, raising in_stall. Each result carries a status, the popped
// value, the match position and the number of entries held after the action.

module bounded_deque_with_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bdq_pkg::ACT_W-1:0]     action,
	input  logic signed [bdq_pkg::DATA_W-1:0] value_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdq_pkg::STAT_W-1:0]    status,
	output logic signed [bdq_pkg::DATA_W-1:0] value_out,
	output logic [bdq_pkg::POS_W-1:0]     position,
	output logic [bdq_pkg::COUNT_W-1:0]   count
);
	import bdq_pkg::*;

	logic                 accept;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic [CNT_W-1:0]     count_m1;
	cell_op_t             ops      [DEPTH];
	logic [DATA_W-1:0]    cell_data[DEPTH];
	logic [DEPTH-1:0]     cell_hit;
	logic [DEPTH-1:0]     held_hit;
	srch_t                srch;
	status_t              stat_nxt;
	logic [DATA_W-1:0]    vout_nxt;
	logic [IDX_W-1:0]     pos_nxt;

	logic                 out_valid_q;
	status_t              status_q;
	logic [DATA_W-1:0]    value_out_q;
	logic [IDX_W-1:0]     pos_q;

	logic [IDX_W+POS_W-1:0]   pos_ext;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	// Handshake: the result register frees itself when its beat is taken.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Row of cells; the front cell takes value_in on a front push, the back cell holds.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] prev_d;
		logic [DATA_W-1:0] next_d;

		if (g == 0) begin : g_front
			assign prev_d = value_in;
		end else begin : g_mid_f
			assign prev_d = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_back
			assign next_d = cell_data[g];
		end else begin : g_mid_b
			assign next_d = cell_data[g+1];
		end

		bdq_cell u_cell (
			.clk       (clk),
			.op        (ops[g]),
			.prev_data (prev_d),
			.next_data (next_d),
			.load_data (value_in),
			.key       (value_in),
			.data      (cell_data[g]),
			.hit       (cell_hit[g])
		);

		// Only held entries take part in the search.
		assign held_hit[g] = cell_hit[g] && (CNT_W'(g) < count_q);
	end

	bdq_search u_search (
		.hits   (held_hit),
		.result (srch)
	);

	assign count_m1 = count_q - 1'b1;

	// Action decode: cell operations, next count and result fields.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ops[i] = CELL_HOLD;
		end
		count_nxt = count_q;
		stat_nxt  = ST_OK;
		vout_nxt  = '0;
		pos_nxt   = '0;
		case (action)
			ACT_PUSH_FRONT: begin
				if (count_q == CNT_W'(DEPTH)) begin
					stat_nxt = ST_FULL;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						ops[i] = accept ? CELL_SHR : CELL_HOLD;
					end
					count_nxt = count_q + 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				if (count_q == CNT_W'(DEPTH)) begin
					stat_nxt = ST_FULL;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (accept && (count_q == CNT_W'(i))) begin
							ops[i] = CELL_LOAD;
						end
					end
					count_nxt = count_q + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (count_q == '0) begin
					stat_nxt = ST_EMPTY;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						ops[i] = accept ? CELL_SHL : CELL_HOLD;
					end
					vout_nxt  = cell_data[0];
					count_nxt = count_m1;
				end
			end
			ACT_POP_BACK: begin
				if (count_q == '0) begin
					stat_nxt = ST_EMPTY;
				end else begin
					vout_nxt  = cell_data[count_m1[IDX_W-1:0]];
					count_nxt = count_m1;
				end
			end
			ACT_SEARCH: begin
				if (srch.found) begin
					pos_nxt = srch.idx;
				end else begin
					stat_nxt = ST_NOT_FOUND;
				end
			end
			default: begin
				stat_nxt = ST_OK;
			end
		endcase
	end

	// Control state: entry count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= stat_nxt;
			value_out_q <= vout_nxt;
			pos_q       <= pos_nxt;
		end
	end

	// Fit the internal index and count to the field widths.
	assign pos_ext = {{POS_W{1'b0}}, pos_q};
	assign cnt_ext = {{COUNT_W{1'b0}}, count_q};

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value_out = value_out_q;
	assign position  = pos_ext[POS_W-1:0];
	assign count     = cnt_ext[COUNT_W-1:0];

endmodule
